// ===== sv/pds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the polyline segment densifier.
// No dependencies; every other file depends on this package.
package pds_pkg;

	localparam int FIELDS     = 6;
	localparam int GEO_FIELDS = 3;
	localparam int MAG_W      = 33;
	localparam int SQ_W       = 66;
	localparam int RAD_W      = 68;
	localparam int ROOT_W     = 34;
	localparam int REM_W      = 36;
	localparam int CNT_W      = 6;

	localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(MAG_W - 1);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(MAG_W - 1);

	typedef struct packed {
		logic               start_of_line;
		logic               end_of_line;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] extra_a;
		logic signed [31:0] extra_b;
		logic signed [31:0] extra_c;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_extra_a;
		logic signed [31:0] out_extra_b;
		logic signed [31:0] out_extra_c;
		logic               last_of_run;
		logic               saturated;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_DIFF,
		ST_SQR,
		ST_SQRT,
		ST_SRCH,
		ST_DIVL,
		ST_DIV,
		ST_EMIT,
		ST_END
	} state_t;

endpackage
`default_nettype wire

// ===== sv/pds_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input point channel: valid/ready handshake with an in_t payload.
// Depends on pds_pkg.
interface pds_in_if;
	logic          valid;
	logic          ready;
	pds_pkg::in_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pds_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output point channel: valid/ready handshake with an out_t payload.
// Depends on pds_pkg.
interface pds_out_if;
	logic          valid;
	logic          ready;
	pds_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/polyline_segment_densifier_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Polyline segment densifier. Per segment: a difference step, bit-serial squaring,
// a bit-serial square root, a search for the count n (at most MAX_SUBDIV), a
// divider load and a bit-serial divide, then n results plus one at an end mark,
// one per cycle while the output is ready.
// A point that only starts a line is held; a single-point line is output as is.
// arst_n clears control state, step_length to 65536 and the held point.
module polyline_segment_densifier_core #(
	parameter int MAX_SUBDIV       = 32,
	parameter int NUM_EXTRA_FIELDS = 3
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [30:0] cfg_data,
	pds_in_if.sink     in_ch,
	pds_out_if.source  out_ch
);
	import pds_pkg::*;

	localparam int NW = $clog2(MAX_SUBDIV + 1);
	localparam int KW = 31 + NW;
	localparam int CW = (KW > ROOT_W + 1) ? KW : ROOT_W + 1;
	localparam logic [NW-1:0] KMAX = NW'(MAX_SUBDIV);

	state_t state_q, state_d;

	logic [30:0]        step_q;
	logic               have_q;
	logic signed [31:0] prev_q [FIELDS];
	logic signed [31:0] cur_q  [FIELDS];
	logic signed [31:0] in_pt  [FIELDS];
	logic               end_q;
	logic               sat_q;
	logic [MAG_W-1:0]   mag_q  [FIELDS];
	logic               neg_q  [FIELDS];
	logic [MAG_W-1:0]   sb_q   [GEO_FIELDS];
	logic [SQ_W-1:0]    sum_q;
	logic [RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CW-1:0]      t_q;
	logic [CW-1:0]      ks_q;
	logic [NW-1:0]      kk_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      k_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]   q_q    [FIELDS];
	logic [NW-1:0]      r_q    [FIELDS];
	logic [MAG_W-1:0]   qd     [FIELDS];
	logic [NW-1:0]      rd     [FIELDS];
	logic signed [31:0] pt     [FIELDS];
	out_t               out_q;
	logic               ovalid_q;

	logic in_acc, slot_free, first_pt, ks_hit, out_load;
	logic [SQ_W-1:0]   sq_add;
	logic [REM_W+1:0]  work, trial;
	logic              root_ge;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign slot_free   = !ovalid_q || out_ch.ready;
	assign first_pt    = in_ch.data.start_of_line || !have_q;
	assign ks_hit      = ks_q >= t_q;
	assign out_load    = slot_free && (state_q == ST_SINGLE || state_q == ST_EMIT ||
		state_q == ST_END);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		in_pt[0] = in_ch.data.coord_x;
		in_pt[1] = in_ch.data.coord_y;
		in_pt[2] = in_ch.data.coord_z;
		in_pt[3] = (NUM_EXTRA_FIELDS > 0) ? in_ch.data.extra_a : '0;
		in_pt[4] = (NUM_EXTRA_FIELDS > 1) ? in_ch.data.extra_b : '0;
		in_pt[5] = (NUM_EXTRA_FIELDS > 2) ? in_ch.data.extra_c : '0;
	end

	// sum of squares, msb first: shift and add the selected magnitudes
	always_comb begin
		sq_add = '0;
		for (int f = 0; f < GEO_FIELDS; f++)
			if (sb_q[f][MAG_W-1])
				sq_add = sq_add + SQ_W'(mag_q[f]);
	end

	assign work    = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign root_ge = work >= trial;

	always_comb begin
		for (int f = 0; f < FIELDS; f++) begin
			logic [MAG_W:0] qx;
			logic [33:0]    sv;
			qx = {1'b0, q_q[f]};
			sv = {{2{prev_q[f][31]}}, prev_q[f]} + (neg_q[f] ? -qx : qx);
			pt[f] = sv[31:0];
		end
	end

	genvar g;
	generate
		for (g = 0; g < FIELDS; g++) begin : g_lane
			pds_div_lane #(.NW(NW)) u_div (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (state_q == ST_DIVL),
				.run      (state_q == ST_DIV),
				.dividend (mag_q[g]),
				.divisor  (n_q),
				.quo      (qd[g]),
				.rem      (rd[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (first_pt)
						state_d = in_ch.data.end_of_line ? ST_SINGLE : ST_IDLE;
					else
						state_d = ST_DIFF;
				end
			end
			ST_SINGLE: if (slot_free) state_d = ST_IDLE;
			ST_DIFF:   state_d = ST_SQR;
			ST_SQR:    if (cnt_q == SQR_LAST) state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == ROOT_LAST) state_d = ST_SRCH;
			ST_SRCH:   if (ks_hit || kk_q == KMAX) state_d = ST_DIVL;
			ST_DIVL:   state_d = ST_DIV;
			ST_DIV:    if (cnt_q == DIV_LAST) state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free && k_q == n_q - NW'(1))
					state_d = end_q ? ST_END : ST_IDLE;
			end
			ST_END:    if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= 31'd65536;
			have_q   <= 1'b0;
			ovalid_q <= 1'b0;
			for (int f = 0; f < FIELDS; f++)
				prev_q[f] <= '0;
		end else begin
			if (cfg_we)
				step_q <= cfg_data;
			if (out_ch.ready && !out_load)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && first_pt && !in_ch.data.end_of_line) begin
						have_q <= 1'b1;
						for (int f = 0; f < FIELDS; f++)
							prev_q[f] <= in_pt[f];
					end else if (in_acc && first_pt) begin
						have_q <= 1'b0;
					end
				end
				ST_SINGLE: if (slot_free) ovalid_q <= 1'b1;
				ST_EMIT: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						if (k_q == n_q - NW'(1) && !end_q)
							for (int f = 0; f < FIELDS; f++)
								prev_q[f] <= cur_q[f];
					end
				end
				ST_END: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						have_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					end_q <= in_ch.data.end_of_line;
					for (int f = 0; f < FIELDS; f++)
						cur_q[f] <= in_pt[f];
				end
			end
			ST_SINGLE: begin
				if (slot_free) begin
					out_q <= '{cur_q[0], cur_q[1], cur_q[2], cur_q[3], cur_q[4], cur_q[5],
						1'b1, 1'b0};
				end
			end
			ST_DIFF: begin
				for (int f = 0; f < FIELDS; f++) begin
					logic signed [32:0] d;
					d = {cur_q[f][31], cur_q[f]} - {prev_q[f][31], prev_q[f]};
					neg_q[f] <= d[32];
					mag_q[f] <= d[32] ? MAG_W'(-{d[32], d}) : MAG_W'(d);
				end
				for (int f = 0; f < GEO_FIELDS; f++) begin
					logic signed [32:0] e;
					e = {cur_q[f][31], cur_q[f]} - {prev_q[f][31], prev_q[f]};
					sb_q[f] <= e[32] ? MAG_W'(-{e[32], e}) : MAG_W'(e);
				end
				sum_q <= '0;
				cnt_q <= '0;
			end
			ST_SQR: begin
				sum_q <= {sum_q[SQ_W-2:0], 1'b0} + sq_add;
				for (int f = 0; f < GEO_FIELDS; f++)
					sb_q[f] <= {sb_q[f][MAG_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == SQR_LAST) begin
					rad_q  <= {2'b00, {sum_q[SQ_W-2:0], 1'b0} + sq_add};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q  <= root_ge ? REM_W'(work - trial) : work[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], root_ge};
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == ROOT_LAST) begin
					// round the root up unless the sum of squares is exact
					t_q  <= CW'({root_q[ROOT_W-2:0], root_ge}) +
						CW'((root_ge ? REM_W'(work - trial) : work[REM_W-1:0]) != '0);
					ks_q <= CW'(step_q);
					kk_q <= NW'(1);
				end
			end
			ST_SRCH: begin
				if (ks_hit) begin
					n_q   <= kk_q;
					sat_q <= 1'b0;
				end else if (kk_q == KMAX) begin
					n_q   <= KMAX;
					sat_q <= 1'b1;
				end else begin
					kk_q <= kk_q + NW'(1);
					ks_q <= ks_q + CW'(step_q);
				end
				cnt_q <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CNT_W'(1);
				k_q   <= '0;
				for (int f = 0; f < FIELDS; f++) begin
					q_q[f] <= '0;
					r_q[f] <= '0;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_q <= '{pt[0], pt[1], pt[2], pt[3], pt[4], pt[5],
						(k_q == n_q - NW'(1)) && !end_q, sat_q};
					k_q <= k_q + NW'(1);
					for (int f = 0; f < FIELDS; f++) begin
						logic [NW:0] rs;
						logic        wrap;
						rs   = {1'b0, r_q[f]} + {1'b0, rd[f]};
						wrap = rs >= {1'b0, n_q};
						r_q[f] <= wrap ? NW'(rs - {1'b0, n_q}) : rs[NW-1:0];
						q_q[f] <= q_q[f] + qd[f] + MAG_W'(wrap);
					end
				end
			end
			ST_END: begin
				if (slot_free) begin
					out_q <= '{cur_q[0], cur_q[1], cur_q[2], cur_q[3], cur_q[4], cur_q[5],
						1'b1, sat_q};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/pds_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial restoring divider lane: 33-bit magnitude by a narrow count.
// One quotient bit per cycle while run is high. Depends on pds_pkg.
module pds_div_lane #(
	parameter int NW = 6
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             load,
	input  wire                             run,
	input  wire  [pds_pkg::MAG_W-1:0]       dividend,
	input  wire  [NW-1:0]                   divisor,
	output logic [pds_pkg::MAG_W-1:0]       quo,
	output logic [NW-1:0]                   rem
);
	import pds_pkg::*;

	logic [MAG_W-1:0] a_q;
	logic [NW-1:0]    rem_q;
	logic [NW:0]      trial;
	logic             fits;

	assign trial = {rem_q, a_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			rem_q <= '0;
		end else if (load) begin
			a_q   <= dividend;
			rem_q <= '0;
		end else if (run) begin
			a_q   <= {a_q[MAG_W-2:0], fits};
			rem_q <= fits ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
		end
	end

	assign quo = a_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

// ===== sv/pds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the densifier core, attached by bind.
// Depends on pds_pkg and polyline_segment_densifier_core.
module pds_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 in_eol,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire pds_pkg::out_t  out_data
);
	import pds_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// an end mark always produces at least one result, so the core goes busy
	a_eol_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eol |=> !in_ready)
		else $error("end-of-line request did not start a run");

	// a run is not finished while a non-final result is shown
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_of_run |-> !in_ready)
		else $error("input taken in the middle of a run");
endmodule

bind polyline_segment_densifier_core pds_checker u_pds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_eol    (in_ch.data.end_of_line),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
`default_nettype wire
